[rtl/ssch_pkg.sv]
// shared types and constants of the stride scheduler
// no dependencies
`timescale 1ns / 1ps

package ssch_pkg;

    localparam int MAX_JOBS = 16;
    localparam int SLOT_W   = $clog2(MAX_JOBS);
    localparam int NUM_W    = 20;
    localparam int PRIO_W   = 16;
    localparam int PASS_W   = 32;
    localparam int ID_W     = 8;

    localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(100000);

    localparam logic [2:0] ACT_NEW       = 3'd0;
    localparam logic [2:0] ACT_INTERRUPT = 3'd1;
    localparam logic [2:0] ACT_FINISH    = 3'd2;
    localparam logic [2:0] ACT_BLOCK     = 3'd3;
    localparam logic [2:0] ACT_UNBLOCK   = 3'd4;

    localparam logic [2:0] OUT_OK          = 3'd0;
    localparam logic [2:0] OUT_IDLE        = 3'd1;
    localparam logic [2:0] OUT_NOT_BLOCKED = 3'd2;
    localparam logic [2:0] OUT_FULL        = 3'd3;
    localparam logic [2:0] OUT_BAD         = 3'd4;

    localparam logic [1:0] JS_RUNNABLE = 2'd0;
    localparam logic [1:0] JS_RUNNING  = 2'd1;
    localparam logic [1:0] JS_BLOCKED  = 2'd2;

    typedef struct packed {
        logic [2:0]        action;
        logic [ID_W-1:0]   job_id;
        logic [PRIO_W-1:0] priority_req;
    } t_in;

    typedef struct packed {
        logic [2:0]        outcome;
        logic [ID_W-1:0]   affected_job;
        logic              scheduled_valid;
        logic [ID_W-1:0]   scheduled_job;
        logic              became_idle;
        logic [PASS_W-1:0] assigned_pass;
    } t_out;

    typedef struct packed {
        logic load;
        logic scan1;
        logic apply;
        logic scan2;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic div_busy;
        logic need_disp;
    } t_dp_stat;

endpackage

[rtl/ssch_div.sv]
// bit-serial restoring divider for the stride, one quotient bit per cycle
// depends on ssch_pkg
`timescale 1ns / 1ps

module ssch_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ssch_pkg::NUM_W-1:0]  i_dividend,
    input  logic [ssch_pkg::PRIO_W-1:0] i_divisor,
    output logic                      o_busy,
    output logic [ssch_pkg::NUM_W-1:0]  o_quotient
);
    import ssch_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [PRIO_W:0]   r_rem, n_rem;
    logic [NUM_W-1:0]  r_quo, n_quo;
    logic [PRIO_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic [PRIO_W:0]   w_shift;

    always_comb begin
        w_shift = {r_rem[PRIO_W-1:0], r_quo[NUM_W-1]};
        if (w_shift >= {1'b0, r_den}) begin
            n_rem = w_shift - {1'b0, r_den};
            n_quo = {r_quo[NUM_W-2:0], 1'b1};
        end else begin
            n_rem = w_shift;
            n_quo = {r_quo[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

[rtl/ssch_datapath.sv]
// job table, scan accumulators, stride divider and result register
// depends on ssch_pkg and ssch_div
`timescale 1ns / 1ps

module ssch_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ssch_pkg::t_dp_cmd        i_cmd,
    output ssch_pkg::t_dp_stat       o_stat,
    input  ssch_pkg::t_in            i_data,
    output ssch_pkg::t_out           o_data,
    input  logic                     i_cfg_valid,
    input  logic [ssch_pkg::NUM_W-1:0] i_cfg_data
);
    import ssch_pkg::*;

    logic              r_ent_valid  [MAX_JOBS];
    logic [1:0]        r_ent_state  [MAX_JOBS];
    logic [ID_W-1:0]   r_ent_id     [MAX_JOBS];
    logic [PASS_W-1:0] r_ent_pass   [MAX_JOBS];
    logic [NUM_W-1:0]  r_ent_stride [MAX_JOBS];
    logic [PASS_W-1:0] r_last_pass;
    logic [NUM_W-1:0]  r_num;
    logic [SLOT_W-1:0] r_idx;
    t_in               r_in;
    t_out              r_out;

    logic              r_dup, r_free_found, r_active, r_run_found, r_blk_found;
    logic [SLOT_W-1:0] r_free_slot, r_run_slot, r_blk_slot;
    logic [PASS_W-1:0] r_min_pass, r_run_pass;
    logic [ID_W-1:0]   r_run_id;
    logic [NUM_W-1:0]  r_run_stride;

    logic              r_best_found, r_act2;
    logic [SLOT_W-1:0] r_best_slot;
    logic [PASS_W-1:0] r_best_pass;
    logic [ID_W-1:0]   r_best_id;

    logic              e_valid, e_active, e_runnable;
    logic [1:0]        e_state;
    logic [ID_W-1:0]   e_id;
    logic [PASS_W-1:0] e_pass;

    logic [PASS_W-1:0] w_join, w_sat;
    logic [PASS_W:0]   w_sum;
    logic              w_new_ok, w_unb_ok, w_run_op, w_is_run_act, w_need, w_idle_end;
    logic [2:0]        w_outcome;
    logic [ID_W-1:0]   w_affected;
    logic              w_div_busy;
    logic [NUM_W-1:0]  w_quo;
    logic [MAX_JOBS-1:0] w_run_vec;

    ssch_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.load && (i_data.action == ACT_NEW) && (i_data.priority_req != '0)),
        .i_dividend (r_num),
        .i_divisor  (i_data.priority_req),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // entry under the scan pointer
    always_comb begin
        e_valid    = r_ent_valid[r_idx];
        e_state    = r_ent_state[r_idx];
        e_id       = r_ent_id[r_idx];
        e_pass     = r_ent_pass[r_idx];
        e_active   = e_valid && ((e_state == JS_RUNNABLE) || (e_state == JS_RUNNING));
        e_runnable = e_valid && (e_state == JS_RUNNABLE);
    end

    always_comb begin
        w_join       = r_active ? r_min_pass : r_last_pass;
        w_sum        = {1'b0, r_run_pass} + {{(PASS_W + 1 - NUM_W){1'b0}}, r_run_stride};
        w_sat        = w_sum[PASS_W] ? '1 : w_sum[PASS_W-1:0];
        w_is_run_act = (r_in.action == ACT_INTERRUPT) || (r_in.action == ACT_FINISH)
                       || (r_in.action == ACT_BLOCK);
        w_new_ok     = (r_in.action == ACT_NEW) && (r_in.priority_req != '0) && !r_dup
                       && r_free_found;
        w_unb_ok     = (r_in.action == ACT_UNBLOCK) && r_blk_found;
        w_run_op     = w_is_run_act && r_active && r_run_found;
        w_need       = (w_new_ok || w_unb_ok) ? !r_active : (w_is_run_act && r_active);
        w_idle_end   = ((r_in.action == ACT_FINISH) || (r_in.action == ACT_BLOCK)) && !r_act2;
        w_affected   = '0;
        unique case (r_in.action)
            ACT_NEW: begin
                w_affected = r_in.job_id;
                if (r_in.priority_req == '0 || r_dup) begin
                    w_outcome = OUT_BAD;
                end else if (!r_free_found) begin
                    w_outcome = OUT_FULL;
                end else begin
                    w_outcome = OUT_OK;
                end
            end
            ACT_INTERRUPT, ACT_FINISH, ACT_BLOCK: begin
                w_outcome  = r_active ? OUT_OK : OUT_IDLE;
                w_affected = w_run_op ? r_run_id : '0;
            end
            ACT_UNBLOCK: begin
                w_affected = r_in.job_id;
                w_outcome  = r_blk_found ? OUT_OK : OUT_NOT_BLOCKED;
            end
            default: begin
                w_outcome = OUT_BAD;
            end
        endcase
    end

    // control state and table valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_last_pass <= '0;
            r_num       <= NUM_RESET;
            for (int i = 0; i < MAX_JOBS; i++) begin
                r_ent_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_num <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.scan1 || i_cmd.scan2) begin
                r_idx <= (r_idx == SLOT_W'(MAX_JOBS - 1)) ? '0 : r_idx + SLOT_W'(1);
            end
            if (i_cmd.apply) begin
                r_idx <= '0;
                if (w_new_ok) begin
                    r_ent_valid[r_free_slot] <= 1'b1;
                end
                if (w_run_op && (r_in.action == ACT_FINISH)) begin
                    r_ent_valid[r_run_slot] <= 1'b0;
                end
            end
            if (i_cmd.commit && !w_idle_end && r_best_found) begin
                r_last_pass <= r_best_pass;
            end
        end
    end

    // table payload, scan accumulators and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in         <= i_data;
            r_dup        <= 1'b0;
            r_free_found <= 1'b0;
            r_active     <= 1'b0;
            r_run_found  <= 1'b0;
            r_blk_found  <= 1'b0;
        end
        if (i_cmd.scan1) begin
            if (e_valid && e_id == r_in.job_id) begin
                r_dup <= 1'b1;
            end
            if (!e_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_slot  <= r_idx;
            end
            if (e_active && (!r_active || e_pass < r_min_pass)) begin
                r_active   <= 1'b1;
                r_min_pass <= e_pass;
            end
            if (e_valid && e_state == JS_RUNNING && !r_run_found) begin
                r_run_found  <= 1'b1;
                r_run_slot   <= r_idx;
                r_run_id     <= e_id;
                r_run_pass   <= e_pass;
                r_run_stride <= r_ent_stride[r_idx];
            end
            if (e_valid && e_id == r_in.job_id && e_state == JS_BLOCKED && !r_blk_found) begin
                r_blk_found <= 1'b1;
                r_blk_slot  <= r_idx;
            end
        end
        if (i_cmd.apply) begin
            r_best_found          <= 1'b0;
            r_act2                <= 1'b0;
            r_out.outcome         <= w_outcome;
            r_out.affected_job    <= w_affected;
            r_out.scheduled_valid <= 1'b0;
            r_out.scheduled_job   <= '0;
            r_out.became_idle     <= 1'b0;
            r_out.assigned_pass   <= (w_new_ok || w_unb_ok) ? w_join : '0;
            if (w_new_ok) begin
                r_ent_state[r_free_slot]  <= JS_RUNNABLE;
                r_ent_id[r_free_slot]     <= r_in.job_id;
                r_ent_pass[r_free_slot]   <= w_join;
                r_ent_stride[r_free_slot] <= w_quo;
            end
            if (w_unb_ok) begin
                r_ent_state[r_blk_slot] <= JS_RUNNABLE;
                r_ent_pass[r_blk_slot]  <= w_join;
            end
            if (w_run_op) begin
                unique case (r_in.action)
                    ACT_INTERRUPT: begin
                        r_ent_pass[r_run_slot]  <= w_sat;
                        r_ent_state[r_run_slot] <= JS_RUNNABLE;
                    end
                    ACT_BLOCK: begin
                        r_ent_state[r_run_slot] <= JS_BLOCKED;
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (i_cmd.scan2) begin
            if (e_active) begin
                r_act2 <= 1'b1;
            end
            if (e_runnable && (!r_best_found || e_pass < r_best_pass
                    || (e_pass == r_best_pass && e_id < r_best_id))) begin
                r_best_found <= 1'b1;
                r_best_slot  <= r_idx;
                r_best_pass  <= e_pass;
                r_best_id    <= e_id;
            end
        end
        if (i_cmd.commit) begin
            if (w_idle_end) begin
                r_out.became_idle <= 1'b1;
            end else if (r_best_found) begin
                r_ent_state[r_best_slot] <= JS_RUNNING;
                r_out.scheduled_valid    <= 1'b1;
                r_out.scheduled_job      <= r_best_id;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_JOBS; i++) begin
            w_run_vec[i] = r_ent_valid[i] && (r_ent_state[i] == JS_RUNNING);
        end
    end

    assign o_stat.last      = (r_idx == SLOT_W'(MAX_JOBS - 1));
    assign o_stat.div_busy  = w_div_busy;
    assign o_stat.need_disp = w_need;
    assign o_data           = r_out;

    a_one_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_run_vec) <= 1)
        else $error("more than one running job");

    a_commit_sched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_best_found && !w_idle_end) |=> r_out.scheduled_valid)
        else $error("dispatch lost at commit");

    a_apply_no_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply |-> !w_div_busy)
        else $error("apply while stride divide in flight");

endmodule

[rtl/ssch_ctrl.sv]
// command sequencer: load, table scan, apply, dispatch scan, commit, result
// depends on ssch_pkg
`timescale 1ns / 1ps

module ssch_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output ssch_pkg::t_dp_cmd  o_cmd,
    input  ssch_pkg::t_dp_stat i_stat
);
    import ssch_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN1, S_WAIT, S_SCAN2, S_COMMIT, S_OUT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:   if (i_valid) r_state <= S_SCAN1;
                S_SCAN1:  if (i_stat.last) r_state <= S_WAIT;
                S_WAIT: begin
                    if (!i_stat.div_busy) begin
                        r_state <= i_stat.need_disp ? S_SCAN2 : S_OUT;
                    end
                end
                S_SCAN2:  if (i_stat.last) r_state <= S_COMMIT;
                S_COMMIT: r_state <= S_OUT;
                S_OUT:    if (i_ready) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_valid;
        o_cmd.scan1  = (r_state == S_SCAN1);
        o_cmd.apply  = (r_state == S_WAIT) && !i_stat.div_busy;
        o_cmd.scan2  = (r_state == S_SCAN2);
        o_cmd.commit = (r_state == S_COMMIT);
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

endmodule

[rtl/stride_scheduler_core.sv]
// stride scheduler top level: one command in, one result out
// sequence: load, table scan, wait on the stride divide for a new job, then apply,
// then dispatch scan and commit when a dispatch or idle check is due, then the result
// throughput: one command at a time, next accepted the cycle after the result transfer
// reset: synchronous active-low, clears the table valid bits, last pass and sequencer,
// stride numerator returns to 100000; config writes always accepted
`timescale 1ns / 1ps

module stride_scheduler_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  ssch_pkg::t_in              i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output ssch_pkg::t_out             o_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ssch_pkg::NUM_W-1:0] i_cfg_data
);
    import ssch_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    ssch_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    ssch_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_data      (i_data),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data)
    );

    assign o_cfg_ready = 1'b1;

endmodule
